### rtl/ppmp_pkg.sv
// Shared constants, codes and the result word type of the binary PPM parser.
package ppmp_pkg;

   localparam int MAX_DIM_DEFAULT = 4096;

   localparam int BYTE_W  = 8;
   localparam int DIM_O_W = 13;
   localparam int RGB_W   = 24;
   localparam int MAXV_W  = 16;
   localparam int MAXV_CAP = 65535;
   localparam int MAXV_OK  = 255;

   localparam logic [BYTE_W-1:0] CH_P  = 8'h50;
   localparam logic [BYTE_W-1:0] CH_0  = 8'h30;
   localparam logic [BYTE_W-1:0] CH_9  = 8'h39;
   localparam logic [BYTE_W-1:0] CH_NL = 8'h0a;

   typedef enum logic [1:0] {
      KIND_PIXEL,
      KIND_HEADER,
      KIND_ERROR
   } kind_type;

   typedef enum logic [2:0] {
      ERR_MAGIC,
      ERR_FORMAT,
      ERR_ZERO_SIZE,
      ERR_MAX_VALUE,
      ERR_OVERFLOW
   } err_type;

   typedef struct packed {
      logic                last_pixel;
      err_type             error_code;
      logic [DIM_O_W-1:0]  image_height;
      logic [DIM_O_W-1:0]  image_width;
      logic [RGB_W-1:0]    pixel_rgb;
      kind_type            kind;
   } rsp_type;

endpackage

### rtl/ppmp_dec_acc.sv
// Saturating decimal digit accumulator: acc * 10 + digit, clamped to CAP.
module ppmp_dec_acc
   import ppmp_pkg::*;
#(
   parameter int ACC_W = 16,
   parameter int CAP   = 65535
) (
   input  logic [ACC_W-1:0] acc,
   input  logic [3:0]       digit,
   output logic [ACC_W-1:0] sum
);

   localparam int SUM_W = ACC_W + 4;
   localparam logic [SUM_W-1:0] CAP_S = SUM_W'(CAP);

   logic [SUM_W-1:0] acc_s;
   logic [SUM_W-1:0] mul_s;

   assign acc_s = SUM_W'(acc);
   assign mul_s = (acc_s << 3) + (acc_s << 1) + SUM_W'(digit);

   always_comb begin
      if (acc_s > CAP_S || mul_s > CAP_S) begin
         sum = CAP_S[ACC_W-1:0];
      end else begin
         sum = mul_s[ACC_W-1:0];
      end
   end

endmodule

### rtl/ppm_binary_image_parser_core.sv
// Binary PPM (P6 style) stream parser: header checks, size decode and RGB pixel packing.
//
// Takes one file byte per cycle on req_ while req_tready is high and gives header, error and pixel words on rsp_.
// Each byte updates the registered parser state; a result goes to a one-word output
// register, and req_tready stays high as long as that register is empty or is being drained,
// so the sustained rate is one byte per clock. A byte with req_tuser set restarts the parser
// and is taken as the first byte of a new file. After an error or the final pixel, bytes are
// dropped until the next restart. MAX_DIM bounds the accepted width and height.
module ppm_binary_image_parser_core
   import ppmp_pkg::*;
#(
   parameter int MAX_DIM = MAX_DIM_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // data_byte [7:0]
   input  logic        req_tuser,   // start_of_file
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [55:0] rsp_tdata,   // pixel_rgb [23:0], image_width [36:24],
                                    // image_height [49:37], error_code [52:50], zero [55:53]
   output logic [1:0]  rsp_tuser,   // kind
   output logic        rsp_tlast    // last_pixel
);

   localparam int DIM_CAP = MAX_DIM + 1;
   localparam int DIM_W   = $clog2(DIM_CAP + 1);
   localparam int TOT_W   = 2 * DIM_W;
   localparam logic [DIM_W-1:0]  MAX_DIM_V = DIM_W'(MAX_DIM);
   localparam logic [MAXV_W-1:0] MAXV_OK_V = MAXV_W'(MAXV_OK);

   typedef enum logic [2:0] {
      PH_MAGIC,
      PH_FORMAT,
      PH_SKIP,
      PH_SIZE,
      PH_MAXV,
      PH_PIXELS,
      PH_DONE,
      PH_ERROR
   } phase_type;

   typedef enum logic [1:0] {
      RUN_NONE,
      RUN_WIDTH,
      RUN_HEIGHT,
      RUN_MAX
   } run_type;

   phase_type           phase_ff, phase_in, phase_cur;
   run_type             run_ff, run_in, run_cur, run_sel;
   logic [DIM_W-1:0]    width_ff, width_in, width_cur;
   logic [DIM_W-1:0]    height_ff, height_in, height_cur;
   logic [MAXV_W-1:0]   maxv_ff, maxv_in, maxv_cur;
   logic [TOT_W-1:0]    total_ff, total_in, total_cur;
   logic [TOT_W-1:0]    count_ff, count_in, count_cur, count_nxt;
   logic [1:0]          bip_ff, bip_in, bip_cur;
   logic [15:0]         part_ff, part_in, part_cur;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_type             rsp_ff, rsp_in;
   rsp_type             rsp_nxt;
   logic                rsp_load;

   logic                req_acc;
   logic [BYTE_W-1:0]   byte_v;
   logic                is_digit;
   logic [3:0]          digit;
   logic [DIM_W-1:0]    dim_acc, dim_sum;
   logic [MAXV_W-1:0]   maxv_sum;
   logic [TOT_W-1:0]    dim_prod;
   logic [DIM_W+DIM_O_W-1:0] width_ext, height_ext;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_acc    = req_tvalid && req_tready;
   assign byte_v     = req_tdata;
   assign is_digit   = (byte_v >= CH_0) && (byte_v <= CH_9);
   assign digit      = 4'(byte_v - CH_0);

   // restart view of the state
   always_comb begin
      if (req_tuser) begin
         phase_cur  = PH_MAGIC;
         run_cur    = RUN_NONE;
         width_cur  = '0;
         height_cur = '0;
         maxv_cur   = '0;
         total_cur  = '0;
         count_cur  = '0;
         bip_cur    = '0;
         part_cur   = '0;
      end else begin
         phase_cur  = phase_ff;
         run_cur    = run_ff;
         width_cur  = width_ff;
         height_cur = height_ff;
         maxv_cur   = maxv_ff;
         total_cur  = total_ff;
         count_cur  = count_ff;
         bip_cur    = bip_ff;
         part_cur   = part_ff;
      end
   end

   // pick which dimension a digit feeds
   always_comb begin
      run_sel = run_cur;
      if (run_cur == RUN_NONE) begin
         if (width_cur == '0) begin
            run_sel = RUN_WIDTH;
         end else if (height_cur == '0) begin
            run_sel = RUN_HEIGHT;
         end
      end
   end

   assign dim_acc    = (run_sel == RUN_HEIGHT) ? height_cur : width_cur;
   assign dim_prod   = TOT_W'(width_cur) * TOT_W'(height_cur);
   assign count_nxt  = count_cur + TOT_W'(1);
   assign width_ext  = {{DIM_O_W{1'b0}}, width_cur};
   assign height_ext = {{DIM_O_W{1'b0}}, height_cur};

   ppmp_dec_acc #(
      .ACC_W (DIM_W),
      .CAP   (DIM_CAP)
   ) u_dim_acc (
      .acc   (dim_acc),
      .digit (digit),
      .sum   (dim_sum)
   );

   ppmp_dec_acc #(
      .ACC_W (MAXV_W),
      .CAP   (MAXV_CAP)
   ) u_maxv_acc (
      .acc   (maxv_cur),
      .digit (digit),
      .sum   (maxv_sum)
   );

   always_comb begin
      phase_in  = phase_ff;
      run_in    = run_ff;
      width_in  = width_ff;
      height_in = height_ff;
      maxv_in   = maxv_ff;
      total_in  = total_ff;
      count_in  = count_ff;
      bip_in    = bip_ff;
      part_in   = part_ff;
      rsp_load  = 1'b0;
      rsp_nxt   = '0;
      if (req_acc) begin
         phase_in  = phase_cur;
         run_in    = run_cur;
         width_in  = width_cur;
         height_in = height_cur;
         maxv_in   = maxv_cur;
         total_in  = total_cur;
         count_in  = count_cur;
         bip_in    = bip_cur;
         part_in   = part_cur;
         unique case (phase_cur)
            PH_MAGIC: begin
               if (byte_v != CH_P) begin
                  phase_in           = PH_ERROR;
                  run_in             = RUN_NONE;
                  rsp_load           = 1'b1;
                  rsp_nxt.kind       = KIND_ERROR;
                  rsp_nxt.error_code = ERR_MAGIC;
               end else begin
                  phase_in = PH_FORMAT;
               end
            end
            PH_FORMAT: begin
               if (byte_v == CH_0) begin
                  phase_in           = PH_ERROR;
                  run_in             = RUN_NONE;
                  rsp_load           = 1'b1;
                  rsp_nxt.kind       = KIND_ERROR;
                  rsp_nxt.error_code = ERR_FORMAT;
               end else begin
                  phase_in = PH_SKIP;
               end
            end
            PH_SKIP: begin
               phase_in = PH_SIZE;
            end
            PH_SIZE: begin
               if (is_digit) begin
                  run_in = run_sel;
                  if (run_sel == RUN_WIDTH) begin
                     width_in = dim_sum;
                  end else if (run_sel == RUN_HEIGHT) begin
                     height_in = dim_sum;
                  end
               end else begin
                  run_in = RUN_NONE;
                  if (byte_v == CH_NL) begin
                     if (width_cur == '0 || height_cur == '0) begin
                        phase_in           = PH_ERROR;
                        rsp_load           = 1'b1;
                        rsp_nxt.kind       = KIND_ERROR;
                        rsp_nxt.error_code = ERR_ZERO_SIZE;
                     end else if (width_cur > MAX_DIM_V || height_cur > MAX_DIM_V) begin
                        phase_in           = PH_ERROR;
                        rsp_load           = 1'b1;
                        rsp_nxt.kind       = KIND_ERROR;
                        rsp_nxt.error_code = ERR_OVERFLOW;
                     end else begin
                        total_in = dim_prod;
                        phase_in = PH_MAXV;
                     end
                  end
               end
            end
            PH_MAXV: begin
               if (is_digit) begin
                  if (run_cur == RUN_NONE && maxv_cur == '0) begin
                     run_in  = RUN_MAX;
                     maxv_in = maxv_sum;
                  end else if (run_cur == RUN_MAX) begin
                     maxv_in = maxv_sum;
                  end
               end else begin
                  run_in = RUN_NONE;
                  if (byte_v == CH_NL) begin
                     rsp_load = 1'b1;
                     if (maxv_cur != MAXV_OK_V) begin
                        phase_in           = PH_ERROR;
                        rsp_nxt.kind       = KIND_ERROR;
                        rsp_nxt.error_code = ERR_MAX_VALUE;
                     end else begin
                        phase_in             = PH_PIXELS;
                        rsp_nxt.kind         = KIND_HEADER;
                        rsp_nxt.image_width  = width_ext[DIM_O_W-1:0];
                        rsp_nxt.image_height = height_ext[DIM_O_W-1:0];
                     end
                  end
               end
            end
            PH_PIXELS: begin
               if (bip_cur < 2'd2) begin
                  part_in = {part_cur[7:0], byte_v};
                  bip_in  = bip_cur + 2'd1;
               end else begin
                  bip_in             = '0;
                  part_in            = '0;
                  count_in           = count_nxt;
                  rsp_load           = 1'b1;
                  rsp_nxt.kind       = KIND_PIXEL;
                  rsp_nxt.pixel_rgb  = {part_cur, byte_v};
                  rsp_nxt.last_pixel = (count_nxt >= total_cur);
                  if (count_nxt >= total_cur) begin
                     phase_in = PH_DONE;
                  end
               end
            end
            PH_DONE, PH_ERROR: begin
               phase_in = phase_cur;
            end
            default: begin
               phase_in = phase_cur;
            end
         endcase
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
         rsp_in       = rsp_nxt;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_MAGIC;
         run_ff       <= RUN_NONE;
         width_ff     <= '0;
         height_ff    <= '0;
         maxv_ff      <= '0;
         total_ff     <= '0;
         count_ff     <= '0;
         bip_ff       <= '0;
         part_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         run_ff       <= run_in;
         width_ff     <= width_in;
         height_ff    <= height_in;
         maxv_ff      <= maxv_in;
         total_ff     <= total_in;
         count_ff     <= count_in;
         bip_ff       <= bip_in;
         part_ff      <= part_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_ff.kind;
   assign rsp_tlast  = rsp_ff.last_pixel;
   assign rsp_tdata  = {3'b000, rsp_ff.error_code, rsp_ff.image_height,
                        rsp_ff.image_width, rsp_ff.pixel_rgb};

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_PIXELS |-> count_ff < total_ff)
      else $error("pixel count reached total while still in pixel phase");

   a_header_enters_pixels: assert property (@(posedge clock) disable iff (reset)
      rsp_load && rsp_nxt.kind == KIND_HEADER |=> phase_ff == PH_PIXELS && count_ff == '0)
      else $error("header word not followed by pixel phase");

   a_last_is_pixel: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |-> rsp_tuser == KIND_PIXEL)
      else $error("last flag on a non-pixel word");

   a_error_parks: assert property (@(posedge clock) disable iff (reset)
      rsp_load && rsp_nxt.kind == KIND_ERROR |=> phase_ff == PH_ERROR && run_ff == RUN_NONE)
      else $error("error word without entering error phase");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_tready |-> !rsp_load)
      else $error("result register overwritten while stalled");

endmodule
